// ----- hw/rtl/rmsn_pkg.sv -----
// Package with the shared constants, types and state encoding of the RMS normaliser.
`timescale 1ns / 1ps
package rmsn_pkg;

    localparam int MAX_HIDDEN   = 64;
    localparam int MAX_BRANCHES = 16;
    localparam int SAMPLE_BITS  = 16;
    localparam int TABLE_SIZE   = MAX_HIDDEN * MAX_BRANCHES;
    localparam int HID_W        = 7;
    localparam int HIDX_W       = $clog2(MAX_HIDDEN);
    localparam int NB_W         = 5;
    localparam int BR_W         = $clog2(MAX_BRANCHES);
    localparam int ADDR_W       = 10;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_W        = 32;
    localparam int SUM_W        = 37;
    localparam int MEAN_W       = 38;
    localparam int DIV_W        = 41;
    localparam int DVS_W        = 32;
    localparam int RECIP_W      = 29;
    localparam int SQ_W         = 64;
    localparam int EPS_W        = 32;

    localparam logic [CFG_IDX_W-1:0] REG_HIDDEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRANCHES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EPSILON  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd3;

    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_SHARED = 2'd1;
    localparam logic [1:0] MODE_BRANCH = 2'd2;

    localparam logic CMD_SCALE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [HID_W-1:0] RST_HIDDEN   = 7'd64;
    localparam logic [NB_W-1:0]  RST_BRANCHES = 5'd1;
    localparam logic [EPS_W-1:0] RST_EPSILON  = 32'd168;

    localparam logic signed [SAMPLE_BITS-1:0] W_ONE = 16'sd4096;

    typedef enum logic [3:0] {
        S_ACC, S_MEAN_GO, S_MEAN, S_SQRT, S_RECIP,
        S_READ, S_MUL1, S_MUL2, S_ROUND, S_SEND
    } t_state;

    typedef struct packed {
        logic acc_sample;
        logic acc_scale;
        logic mean_start;
        logic sqrt_start;
        logic recip_start;
        logic load_r;
        logic read;
        logic mul1;
        logic mul2;
        logic round;
        logic next;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic group_full;
        logic div_busy;
        logic sqrt_busy;
        logic last_item;
    } t_dp_stat;

endpackage

// ----- hw/rtl/rmsn_in_if.sv -----
// Input channel carrying scale writes and samples.
`timescale 1ns / 1ps
interface rmsn_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [9:0]  scale_address;
    logic signed [15:0] scale_word;
    logic signed [15:0] sample;
    logic        tensor_start;

    modport source (output valid, cmd, scale_address, scale_word, sample, tensor_start,
                    input ready);
    modport sink (input valid, cmd, scale_address, scale_word, sample, tensor_start,
                  output ready);
endinterface

// ----- hw/rtl/rmsn_out_if.sv -----
// Output channel carrying normalised results.
`timescale 1ns / 1ps
interface rmsn_out_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] normalized;
    logic        last;

    modport source (output valid, normalized, last, input ready);
    modport sink (input valid, normalized, last, output ready);
endinterface

// ----- hw/rtl/rmsn_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module rmsn_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rmsn_pkg::DIV_W-1:0] i_dividend,
    input  logic [rmsn_pkg::DVS_W-1:0] i_divisor,
    output logic                      o_busy,
    output logic [rmsn_pkg::DIV_W-1:0] o_quotient
);
    import rmsn_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] r_quo, n_quo;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [DVS_W:0]   trial;

    always_comb begin
        trial = {r_rem, r_quo[DIV_W-1]};
        if (trial >= {1'b0, r_dvs}) begin
            n_rem = DVS_W'(trial - {1'b0, r_dvs});
            n_quo = {r_quo[DIV_W-2:0], 1'b1};
        end else begin
            n_rem = trial[DVS_W-1:0];
            n_quo = {r_quo[DIV_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIV_W - 1);
        end else if (r_busy) begin
            r_busy <= (r_cnt != '0);
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;
endmodule

// ----- hw/rtl/rmsn_dp.sv -----
// Datapath: configuration, buffers, square sum, root, reciprocal and output scaling.
`timescale 1ns / 1ps
module rmsn_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rmsn_pkg::t_dp_cmd             i_cmd,
    output rmsn_pkg::t_dp_stat            o_stat,
    input  logic                          i_cfg_we,
    input  logic [rmsn_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rmsn_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic [rmsn_pkg::ADDR_W-1:0]   i_scale_address,
    input  logic signed [rmsn_pkg::SAMPLE_BITS-1:0] i_scale_word,
    input  logic signed [rmsn_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_tensor_start,
    output logic signed [rmsn_pkg::SAMPLE_BITS-1:0] o_normalized,
    output logic                          o_last
);
    import rmsn_pkg::*;

    logic [HID_W-1:0] r_hidden;
    logic [NB_W-1:0]  r_nbr;
    logic [EPS_W-1:0] r_eps;
    logic [1:0]       r_mode;

    logic [HID_W-1:0] h_eff;
    logic [NB_W-1:0]  nb_eff;

    logic signed [SAMPLE_BITS-1:0] r_buf [MAX_HIDDEN];
    logic signed [SAMPLE_BITS-1:0] r_table [TABLE_SIZE];

    logic [SUM_W-1:0] r_sum;
    logic [HID_W-1:0] r_count;
    logic [BR_W-1:0]  r_branch;
    logic [BR_W-1:0]  br_sel;
    logic [HID_W-1:0] r_k;

    logic [SQ_W-1:0]  r_op, r_res, r_one;
    logic [SQ_W-1:0]  trial;
    logic             r_sq_busy;

    logic             div_start, div_busy;
    logic [DIV_W-1:0] div_dividend, div_quot;
    logic [DVS_W-1:0] div_divisor;
    logic [MEAN_W-1:0] mean;

    logic [RECIP_W-1:0] r_r;
    logic signed [SAMPLE_BITS-1:0] r_x, r_w_raw;
    logic             r_use_w;
    logic [ADDR_W-1:0] tab_addr;
    logic signed [SAMPLE_BITS-1:0] w;
    logic [SAMPLE_BITS-1:0] mx, mw;
    logic [31:0]      r_p1;
    logic [60:0]      r_p2;
    logic             r_neg;
    logic [60:0]      rnd;
    logic [32:0]      q;
    logic [SAMPLE_BITS-1:0] lim, qs;
    logic signed [SAMPLE_BITS-1:0] r_out;
    logic             r_last;
    logic [31:0]      sq;

    always_comb begin
        if (r_hidden == '0) begin
            h_eff = HID_W'(1);
        end else if (r_hidden > HID_W'(MAX_HIDDEN)) begin
            h_eff = HID_W'(MAX_HIDDEN);
        end else begin
            h_eff = r_hidden;
        end
        if (r_nbr == '0) begin
            nb_eff = NB_W'(1);
        end else if (r_nbr > NB_W'(MAX_BRANCHES)) begin
            nb_eff = NB_W'(MAX_BRANCHES);
        end else begin
            nb_eff = r_nbr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hidden <= RST_HIDDEN;
            r_nbr    <= RST_BRANCHES;
            r_eps    <= RST_EPSILON;
            r_mode   <= MODE_NONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_HIDDEN:   r_hidden <= i_cfg_data[HID_W-1:0];
                REG_BRANCHES: r_nbr    <= i_cfg_data[NB_W-1:0];
                REG_EPSILON:  r_eps    <= i_cfg_data[EPS_W-1:0];
                REG_MODE:     r_mode   <= i_cfg_data[1:0];
                default:      r_mode   <= r_mode;
            endcase
        end
    end

    always_comb begin
        br_sel = (r_count == '0 && i_tensor_start) ? '0 : r_branch;
        if ({1'b0, br_sel} >= nb_eff) begin
            br_sel = '0;
        end
        sq = 32'(i_sample * i_sample);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_count  <= '0;
            r_branch <= '0;
        end else if (i_cmd.acc_sample) begin
            r_sum    <= r_sum + SUM_W'(sq);
            r_count  <= r_count + 1'b1;
            r_branch <= br_sel;
        end else if (i_cmd.finish) begin
            r_sum   <= '0;
            r_count <= '0;
            if ({1'b0, r_branch} + 1'b1 >= nb_eff) begin
                r_branch <= '0;
            end else begin
                r_branch <= r_branch + 1'b1;
            end
        end
    end

    assign tab_addr = (r_mode == MODE_BRANCH) ? {r_branch, r_k[HIDX_W-1:0]}
                                              : ADDR_W'(r_k[HIDX_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_sample) begin
            r_buf[r_count[HIDX_W-1:0]] <= i_sample;
        end
        if (i_cmd.read) begin
            r_x <= r_buf[r_k[HIDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_scale) begin
            r_table[i_scale_address] <= i_scale_word;
        end
        if (i_cmd.read) begin
            r_w_raw <= r_table[tab_addr];
            r_use_w <= (r_mode == MODE_SHARED) || (r_mode == MODE_BRANCH);
        end
    end

    assign div_start    = i_cmd.mean_start | i_cmd.recip_start;
    assign div_dividend = i_cmd.recip_start ? (DIV_W'(1) << 40) : DIV_W'(r_sum);
    assign div_divisor  = i_cmd.recip_start ? r_res[DVS_W-1:0] : DVS_W'(r_count);

    rmsn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quotient (div_quot)
    );

    always_comb begin
        mean = MEAN_W'(div_quot[SUM_W-1:0]) + MEAN_W'(r_eps);
        if (mean == '0) begin
            mean = MEAN_W'(1);
        end
        trial = r_res + r_one;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_busy <= 1'b0;
        end else if (i_cmd.sqrt_start) begin
            r_sq_busy <= 1'b1;
        end else if (r_sq_busy) begin
            r_sq_busy <= (r_one[SQ_W-1:2] != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_start) begin
            r_op  <= SQ_W'({mean, 24'd0});
            r_res <= '0;
            r_one <= SQ_W'(1) << 62;
        end else if (r_sq_busy) begin
            if (r_op >= trial) begin
                r_op  <= r_op - trial;
                r_res <= (r_res >> 1) + r_one;
            end else begin
                r_res <= r_res >> 1;
            end
            r_one <= r_one >> 2;
        end
    end

    always_comb begin
        w   = r_use_w ? r_w_raw : W_ONE;
        mx  = r_x[SAMPLE_BITS-1] ? SAMPLE_BITS'(~r_x + 1'b1) : r_x;
        mw  = w[SAMPLE_BITS-1] ? SAMPLE_BITS'(~w + 1'b1) : w;
        rnd = r_p2 + (61'd1 << 27);
        q   = rnd[60:28];
        lim = r_neg ? SAMPLE_BITS'(1 << (SAMPLE_BITS - 1))
                    : SAMPLE_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
        qs  = (q > 33'(lim)) ? lim : q[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_r) begin
            r_r <= div_quot[RECIP_W-1:0];
        end
        if (i_cmd.mul1) begin
            r_p1  <= 32'(mx) * 32'(mw);
            r_neg <= r_x[SAMPLE_BITS-1] ^ w[SAMPLE_BITS-1];
        end
        if (i_cmd.mul2) begin
            r_p2 <= 61'(r_p1) * 61'(r_r);
        end
        if (i_cmd.round) begin
            r_out  <= r_neg ? SAMPLE_BITS'(~qs + 1'b1) : qs;
            r_last <= (r_k == r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (i_cmd.load_r) begin
            r_k <= '0;
        end else if (i_cmd.next) begin
            r_k <= r_k + 1'b1;
        end
    end

    assign o_stat.group_full = ({1'b0, r_count} + 1'b1) >= {1'b0, h_eff};
    assign o_stat.div_busy   = div_busy;
    assign o_stat.sqrt_busy  = r_sq_busy;
    assign o_stat.last_item  = r_last;
    assign o_normalized      = r_out;
    assign o_last            = r_last;
endmodule

// ----- hw/rtl/rmsn_ctrl.sv -----
// Controller state machine sequencing accumulation, root, reciprocal and output.
`timescale 1ns / 1ps
module rmsn_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_cmd,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  rmsn_pkg::t_dp_stat i_stat,
    output rmsn_pkg::t_dp_cmd  o_cmd
);
    import rmsn_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_ACC: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_cmd == CMD_SCALE) begin
                        o_cmd.acc_scale = 1'b1;
                    end else begin
                        o_cmd.acc_sample = 1'b1;
                        if (i_stat.group_full) begin
                            n_state = S_MEAN_GO;
                        end
                    end
                end
            end
            S_MEAN_GO: begin
                o_cmd.mean_start = 1'b1;
                n_state = S_MEAN;
            end
            S_MEAN: begin
                if (!i_stat.div_busy) begin
                    o_cmd.sqrt_start = 1'b1;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (!i_stat.sqrt_busy) begin
                    o_cmd.recip_start = 1'b1;
                    n_state = S_RECIP;
                end
            end
            S_RECIP: begin
                if (!i_stat.div_busy) begin
                    o_cmd.load_r = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_state = S_SEND;
            end
            S_SEND: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_stat.last_item) begin
                        o_cmd.finish = 1'b1;
                        n_state = S_ACC;
                    end else begin
                        o_cmd.next = 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            default: n_state = S_ACC;
        endcase
    end
endmodule

// ----- hw/rtl/branchwise_rms_normalizer_unit.sv -----
// Top level of the branchwise RMS normaliser.
// The input channel takes one item per cycle while the block is gathering a group:
// an item with cmd 0 writes a scale word into the 1024-entry table, an item with
// cmd 1 is a sample that is buffered and whose square is summed.
// When the sample completing a group is taken, the input channel drops ready.
// The group is then processed by one shared iterative divider and a bit-pair
// square-root unit: a set-up state, then the mean, the root and the reciprocal,
// each in turn, before the first result is presented. Each result then passes
// through buffer and table read, two multiplier stages, rounding and the output
// register, and the next result is begun only once the receiver has taken it.
// A stalled receiver holds the output item steady; the block waits and resumes.
// After the last item of a group is taken, samples are accepted again.
// Configuration writes are taken at any cycle but must only be made while idle.
// Reset clears the control state, the square sum, the sample count and the
// branch counter; buffers and the scale table are not cleared.
`timescale 1ns / 1ps
module branchwise_rms_normalizer_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    rmsn_in_if.sink                        i_in,
    rmsn_out_if.source                     o_out,
    input  logic                           i_cfg_we,
    input  logic [rmsn_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rmsn_pkg::CFG_W-1:0]     i_cfg_data
);
    import rmsn_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    rmsn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_cmd    (i_in.cmd),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    rmsn_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_scale_address (i_in.scale_address),
        .i_scale_word    (i_in.scale_word),
        .i_sample        (i_in.sample),
        .i_tensor_start  (i_in.tensor_start),
        .o_normalized    (o_out.normalized),
        .o_last          (o_out.last)
    );
endmodule
